// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSMV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/csmv_pkg.sv -----
// Types and constants of the CSR sparse matrix-vector core.
package csmv_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned ACC_W   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD      = 3'd0,
    OP_ADD       = 3'd1,
    OP_ADD_CLOSE = 3'd2,
    OP_CLOSE     = 3'd3,
    OP_START     = 3'd4
  } op_e;

  typedef struct packed {
    logic        [OP_W-1:0]    op;
    logic        [INDEX_W-1:0] index;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic        [ROW_W-1:0] row;
    logic signed [ACC_W-1:0] y_value;
  } result_t;

endpackage

// ----- rtl/csmv_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
interface csmv_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/csmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/csr_sparse_matvec_core.sv -----
// CSR sparse matrix times dense vector: load x into the store, stream nonzeros
// in row order and take one y result per closed row. The core accepts one
// transaction per clock cycle, loads and nonzeros alike, but the whole pipeline
// holds only while a result sits untaken in the output register. A closing
// transaction's result is registered there once it has passed stages 1 and 2.
// The pipeline is x-store read, one VALUE_BITS x VALUE_BITS multiply, then the
// 64-bit accumulate. A load writes the store at acceptance, so a nonzero right
// behind it already reads the new entry. x entries need no clearing after
// reset; each one must be loaded before a nonzero reads it.
`include "assert_macros.svh"

module csr_sparse_matvec_core #(
  parameter int unsigned X_DEPTH    = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  csmv_stream_if.sink   in_i,
  csmv_stream_if.source out_o
);

  localparam int unsigned ADDR_W = $clog2(X_DEPTH);

  // ---------------------------------------------------------------- intake
  logic en;
  logic accept;
  logic in_hit;
  csmv_pkg::op_e in_op;
  logic [ADDR_W-1:0] in_addr;
  logic [VALUE_BITS-1:0] in_val;

  assign en        = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign accept    = in_i.valid && en;
  assign in_op     = csmv_pkg::op_e'(in_i.data.op);
  assign in_addr   = ADDR_W'(in_i.data.index);
  assign in_val    = in_i.data.value[VALUE_BITS-1:0];
  assign in_hit    = 32'(in_i.data.index) < 32'(X_DEPTH);

  // ---------------------------------------------------------------- x store
  logic [VALUE_BITS-1:0] x_rdata;

  csmv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (X_DEPTH)
  ) u_x_store (
    .clk_i   (clk_i),
    .we_i    (accept && (in_op == csmv_pkg::OP_LOAD) && in_hit),
    .waddr_i (in_addr),
    .wdata_i (in_val),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (x_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  logic                  s1_valid_q;
  csmv_pkg::op_e         s1_op_q;
  logic [VALUE_BITS-1:0] s1_val_q;
  logic                  s1_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= in_op;
      s1_val_q <= in_val;
      s1_hit_q <= in_hit;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [VALUE_BITS-1:0]   mul_a;
  logic signed [VALUE_BITS-1:0]   mul_x;
  logic signed [2*VALUE_BITS-1:0] mul_p;

  assign mul_a = $signed(s1_val_q);
  assign mul_x = s1_hit_q ? $signed(x_rdata) : '0;
  assign mul_p = mul_a * mul_x;

  logic                                  s2_valid_q;
  csmv_pkg::op_e                         s2_op_q;
  logic signed [csmv_pkg::ACC_W-1:0]     s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      s2_op_q   <= s1_op_q;
      s2_prod_q <= csmv_pkg::ACC_W'(mul_p);
    end
  end

  // ---------------------------------------------------------------- accumulate
  logic [csmv_pkg::ACC_W-1:0] acc_q, acc_d, acc_sum;
  logic [csmv_pkg::ROW_W-1:0] row_q, row_d;
  logic                       out_load;
  csmv_pkg::result_t          out_data_d, out_data_q;
  logic                       out_valid_q;

  assign acc_sum = acc_q + s2_prod_q;

  always_comb begin
    acc_d              = acc_q;
    row_d              = row_q;
    out_load           = 1'b0;
    out_data_d.row     = row_q;
    out_data_d.y_value = acc_q;
    if (s2_valid_q) begin
      unique case (s2_op_q)
        csmv_pkg::OP_ADD: begin
          acc_d = acc_sum;
        end
        csmv_pkg::OP_ADD_CLOSE: begin
          out_load           = 1'b1;
          out_data_d.y_value = acc_sum;
          acc_d              = '0;
          row_d              = row_q + csmv_pkg::ROW_W'(1);
        end
        csmv_pkg::OP_CLOSE: begin
          out_load = 1'b1;
          acc_d    = '0;
          row_d    = row_q + csmv_pkg::ROW_W'(1);
        end
        csmv_pkg::OP_START: begin
          acc_d = '0;
          row_d = '0;
        end
        default: ;  // loads and unused codes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      acc_q       <= acc_d;
      row_q       <= row_d;
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------- checks
  `CSMV_ASSERT_NEXT(a_stall_holds_pipe, clk_i, rst_ni, out_o.valid && !out_o.ready,
    $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(acc_q),
    "pipeline moved during output stall")
  `CSMV_ASSERT_NEXT(a_close_gives_result, clk_i, rst_ni,
    en && s2_valid_q && (s2_op_q == csmv_pkg::OP_CLOSE || s2_op_q == csmv_pkg::OP_ADD_CLOSE),
    out_o.valid && acc_q == '0 && out_o.data.row == $past(row_q),
    "row close did not produce a result")
  `CSMV_ASSERT_NEXT(a_start_clears, clk_i, rst_ni,
    en && s2_valid_q && s2_op_q == csmv_pkg::OP_START,
    acc_q == '0 && row_q == '0 && !out_o.valid,
    "start did not clear accumulator and row")
  `CSMV_ASSERT_IMPL(a_ready_tracks_output, clk_i, rst_ni, out_o.valid && !out_o.ready,
    !in_i.ready, "input taken while result stalled")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the CSR sparse matrix-vector core.
module tb;

  // Op codes the core ignores.
  localparam logic [csmv_pkg::OP_W-1:0] OP_RSVD0 = 3'd5;
  localparam logic [csmv_pkg::OP_W-1:0] OP_RSVD1 = 3'd6;
  localparam logic [csmv_pkg::OP_W-1:0] OP_RSVD2 = 3'd7;

  localparam int unsigned X_ENTRIES  = 1 << csmv_pkg::INDEX_W;
  localparam int unsigned ITEM_GOAL  = 850;
  localparam int unsigned DIR_ROWS   = 23;
  localparam int unsigned DRAIN_CYC  = 16;

  typedef struct {
    logic [csmv_pkg::OP_W-1:0]           op;
    logic [csmv_pkg::INDEX_W-1:0]        index;
    logic signed [csmv_pkg::VALUE_W-1:0] value;
    bit                                  typed;
    logic [csmv_pkg::ROW_W-1:0]          row;
    logic signed [csmv_pkg::ACC_W-1:0]   y_value;
  } dir_row_t;

  logic clk;
  logic rst_n;

  csmv_stream_if #(.T(csmv_pkg::item_t))   item_if ();
  csmv_stream_if #(.T(csmv_pkg::result_t)) y_if ();

  csr_sparse_matvec_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_if),
    .out_o  (y_if)
  );

  // Shadow state of the core
  int                           x_mem [X_ENTRIES];
  bit                           x_loaded [X_ENTRIES];
  logic [csmv_pkg::ACC_W-1:0]   acc_q;
  logic [csmv_pkg::ROW_W-1:0]   row_q;
  logic [csmv_pkg::INDEX_W-1:0] loaded_cols [$];

  csmv_pkg::result_t y_expected [$];
  int                n_fail;
  int                n_items;
  bit                no_idle;
  dir_row_t          dir_tab [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** csr_sparse_matvec_core: FAILED **");
    $finish;
  end

  // Advances the shadow state by one accepted transaction; returns 1 when a row closes.
  function automatic bit matvec_step(input csmv_pkg::item_t it, output csmv_pkg::result_t res);
    longint prod;
    bit     closes;
    closes = 1'b0;
    res    = '0;
    case (it.op)
      csmv_pkg::OP_LOAD: begin
        if (!x_loaded[it.index]) loaded_cols.push_back(it.index);
        x_mem[it.index]    = it.value;
        x_loaded[it.index] = 1'b1;
      end
      csmv_pkg::OP_ADD, csmv_pkg::OP_ADD_CLOSE: begin
        prod   = longint'(it.value) * longint'(x_mem[it.index]);
        acc_q  = acc_q + prod;
        closes = (it.op == csmv_pkg::OP_ADD_CLOSE);
      end
      csmv_pkg::OP_CLOSE: closes = 1'b1;
      csmv_pkg::OP_START: begin
        acc_q = '0;
        row_q = '0;
      end
      default: ;
    endcase
    if (closes) begin
      res.row     = row_q;
      res.y_value = acc_q;
      acc_q       = '0;
      row_q       = row_q + csmv_pkg::ROW_W'(1);
    end
    return closes;
  endfunction

  task automatic send_txn(input csmv_pkg::item_t it, input bit typed,
                          input csmv_pkg::result_t typed_res);
    int unsigned       gap;
    csmv_pkg::result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      item_if.valid <= 1'b0;
    end
    @(negedge clk);
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    @(posedge clk);
    while (!(item_if.valid && item_if.ready)) @(posedge clk);
    if (matvec_step(it, res)) y_expected.push_back(typed ? typed_res : res);
    if (it.op <= csmv_pkg::OP_START) n_items++;
  endtask

  function automatic logic [csmv_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [csmv_pkg::INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return csmv_pkg::INDEX_W'($urandom_range(0, X_ENTRIES - 1));
    endcase
  endfunction

  // Only columns already loaded are read.
  function automatic csmv_pkg::item_t nonzero(input logic [csmv_pkg::OP_W-1:0] op);
    csmv_pkg::item_t it;
    it.op    = op;
    it.index = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    it.value = pick_value();
    return it;
  endfunction

  task automatic load_burst(input int unsigned n);
    csmv_pkg::item_t it;
    int unsigned     k;
    for (k = 0; k < n; k++) begin
      it.op    = csmv_pkg::OP_LOAD;
      it.index = pick_index();
      it.value = pick_value();
      send_txn(it, 1'b0, '0);
    end
  endtask

  // Result side: random stall per transaction, compare against the oldest expectation.
  initial begin
    int unsigned       stall;
    csmv_pkg::result_t got;
    csmv_pkg::result_t want;
    y_if.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        y_if.ready <= 1'b0;
      end
      @(negedge clk);
      y_if.ready <= 1'b1;
      @(posedge clk);
      while (!(y_if.valid && y_if.ready && rst_n)) @(posedge clk);
      got = y_if.data;
      if (y_expected.size() == 0) begin
        $error("row: unexpected result, got row %0d y_value %0d", got.row, got.y_value);
        n_fail++;
      end else begin
        want = y_expected.pop_front();
        if (got.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, got.row);
          n_fail++;
        end
        if (got.y_value !== want.y_value) begin
          $error("y_value: expected %0d, got %0d", want.y_value, got.y_value);
          n_fail++;
        end
      end
    end
  end

  initial begin
    csmv_pkg::item_t   it;
    csmv_pkg::result_t tres;
    int unsigned       i;
    int unsigned       n;
    int unsigned       sel;

    rst_n         = 1'b0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    n_fail        = 0;
    n_items       = 0;
    no_idle       = 1'b0;
    acc_q         = '0;
    row_q         = '0;
    for (i = 0; i < X_ENTRIES; i++) begin
      x_mem[i]    = 0;
      x_loaded[i] = 1'b0;
    end

    dir_tab = '{
      // empty row after reset
      '{csmv_pkg::OP_CLOSE,     10'd0,    32'h0000_0000, 1'b1, 16'd0, 64'h0},
      '{OP_RSVD0,               10'd1023, 32'hffff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_LOAD,      10'd0,    32'h0000_0001, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_LOAD,      10'd1023, 32'h8000_0000, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_LOAD,      10'd512,  32'h7fff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_LOAD,      10'd1,    32'hffff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD_CLOSE, 10'd0,    32'h0000_0005, 1'b1, 16'd1, 64'h5},
      '{csmv_pkg::OP_ADD,       10'd1023, 32'h8000_0000, 1'b0, 16'd0, 64'h0},
      // 2 * 2^62 wraps to the most negative value
      '{csmv_pkg::OP_ADD_CLOSE, 10'd1023, 32'h8000_0000, 1'b1, 16'd2, 64'h8000_0000_0000_0000},
      '{csmv_pkg::OP_ADD,       10'd512,  32'h7fff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD,       10'd512,  32'h7fff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD_CLOSE, 10'd1,    32'h8000_0000, 1'b0, 16'd0, 64'h0},
      '{OP_RSVD1,               10'd0,    32'h0000_0000, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_CLOSE,     10'd0,    32'h0000_0000, 1'b1, 16'd4, 64'h0},
      '{csmv_pkg::OP_START,     10'd0,    32'h0000_0000, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_CLOSE,     10'd0,    32'h0000_0000, 1'b1, 16'd0, 64'h0},
      '{csmv_pkg::OP_LOAD,      10'h2aa,  32'h5a5a_5a5a, 1'b0, 16'd0, 64'h0},
      // reads entry just loaded
      '{csmv_pkg::OP_ADD,       10'h2aa,  32'ha5a5_a5a5, 1'b0, 16'd0, 64'h0},
      '{OP_RSVD2,               10'h155,  32'h1234_5678, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD,       10'd0,    32'h7fff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD_CLOSE, 10'd1023, 32'h7fff_ffff, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_ADD,       10'd512,  32'h0000_0003, 1'b0, 16'd0, 64'h0},
      '{csmv_pkg::OP_START,     10'd0,    32'h0000_0000, 1'b0, 16'd0, 64'h0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      it.op          = dir_tab[i].op;
      it.index       = dir_tab[i].index;
      it.value       = dir_tab[i].value;
      tres.row       = dir_tab[i].row;
      tres.y_value   = dir_tab[i].y_value;
      send_txn(it, dir_tab[i].typed, tres);
    end

    load_burst(24);
    while (n_items < ITEM_GOAL) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        it.op    = csmv_pkg::OP_START;
        it.index = csmv_pkg::INDEX_W'($urandom);
        it.value = $urandom;
        send_txn(it, 1'b0, '0);
      end else if (sel < 20) begin
        load_burst($urandom_range(1, 8));
      end else if (sel < 90) begin
        // one matrix row: 0..6 nonzeros, closed by the last nonzero or a bare close
        n = $urandom_range(0, 6);
        for (i = 1; i < n; i++) send_txn(nonzero(csmv_pkg::OP_ADD), 1'b0, '0);
        if (n > 0 && $urandom_range(0, 1)) begin
          send_txn(nonzero(csmv_pkg::OP_ADD_CLOSE), 1'b0, '0);
        end else begin
          if (n > 0) send_txn(nonzero(csmv_pkg::OP_ADD), 1'b0, '0);
          it.op    = csmv_pkg::OP_CLOSE;
          it.index = csmv_pkg::INDEX_W'($urandom);
          it.value = $urandom;
          send_txn(it, 1'b0, '0);
        end
      end else if (sel < 95) begin
        case ($urandom_range(0, 2))
          0: it.op = OP_RSVD0;
          1: it.op = OP_RSVD1;
          default: it.op = OP_RSVD2;
        endcase
        it.index = csmv_pkg::INDEX_W'($urandom);
        it.value = $urandom;
        send_txn(it, 1'b0, '0);
      end else begin
        // stray nonzero that joins the next row
        send_txn(nonzero(csmv_pkg::OP_ADD), 1'b0, '0);
      end
    end

    @(negedge clk);
    item_if.valid <= 1'b0;
    while (y_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_fail == 0) begin
      $display("** csr_sparse_matvec_core: PASSED **");
    end else begin
      $display("** csr_sparse_matvec_core: FAILED **");
    end
    $finish;
  end

endmodule
